[sv/fvh_pkg.sv]
// ----------------------------------------------------------------------------
// fvh_pkg: shared types and constants of the flow vector to HSV coder
// Holds the controller state type, the command and status structs and the
// tangent table that is used for the hue boundary tests, and the quadrant hue offsets.
// ----------------------------------------------------------------------------
package fvh_pkg;

	localparam int FLOW_BITS_DEF = 16;
	localparam int TAN_SHIFT     = 20;
	localparam int ANGLE_STEPS   = 44;
	localparam int DIV_STEPS     = 8;
	localparam int TAN_LAST      = 22;
	localparam int TAN_MIRROR    = 45;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SQUARE,
		ST_SUM,
		ST_ITERATE,
		ST_DIV_PREP,
		ST_DIVIDE,
		ST_FINISH
	} fvh_state_t;

	typedef struct packed {
		logic       load;
		logic       square;
		logic       sum;
		logic       iterate;
		logic       div_prep;
		logic       div_step;
		logic       finish;
		logic [5:0] cnt;
	} fvh_cmd_t;

	typedef struct packed {
		logic out_stall;
	} fvh_status_t;

	// round(tan(2k degrees) * 2^20) for k = 0..22
	function automatic logic [19:0] tan_lut(input logic [4:0] idx);
		logic [19:0] t;
		case (idx)
			5'd0:  t = 20'd0;
			5'd1:  t = 20'd36617;
			5'd2:  t = 20'd73324;
			5'd3:  t = 20'd110210;
			5'd4:  t = 20'd147368;
			5'd5:  t = 20'd184892;
			5'd6:  t = 20'd222882;
			5'd7:  t = 20'd261439;
			5'd8:  t = 20'd300674;
			5'd9:  t = 20'd340703;
			5'd10: t = 20'd381650;
			5'd11: t = 20'd423652;
			5'd12: t = 20'd466856;
			5'd13: t = 20'd511425;
			5'd14: t = 20'd557538;
			5'd15: t = 20'd605396;
			5'd16: t = 20'd655223;
			5'd17: t = 20'd707254;
			5'd18: t = 20'd761835;
			5'd19: t = 20'd819237;
			5'd20: t = 20'd879860;
			5'd21: t = 20'd944142;
			5'd22: t = 20'd1012598;
			default: t = 20'd0;
		endcase
		return t;
	endfunction

	// Hue offset of each quadrant: 45 steps of two degrees per quadrant.
	function automatic logic [7:0] quad_base(input logic [1:0] q);
		logic [7:0] b;
		case (q)
			2'd0: b = 8'd0;
			2'd1: b = 8'd45;
			2'd2: b = 8'd90;
			2'd3: b = 8'd135;
			default: b = 8'd0;
		endcase
		return b;
	endfunction

endpackage

[sv/fvh_if.sv]
// ----------------------------------------------------------------------------
// fvh_if: channel interfaces of the flow vector to HSV coder
// Flow input channel, HSV output channel and configuration write channel.
// ----------------------------------------------------------------------------
interface fvh_flow_if #(parameter int FLOW_BITS = fvh_pkg::FLOW_BITS_DEF);
	logic                        valid;
	logic                        ready;
	logic signed [FLOW_BITS-1:0] flow_x;
	logic signed [FLOW_BITS-1:0] flow_y;
	logic                        frame_last;

	modport source (output valid, flow_x, flow_y, frame_last, input ready);
	modport sink (input valid, flow_x, flow_y, frame_last, output ready);
endinterface

interface fvh_hsv_if;
	logic       valid;
	logic       ready;
	logic [7:0] hue;
	logic [7:0] saturation;
	logic [7:0] brightness;
	logic       frame_end;

	modport source (output valid, hue, saturation, brightness, frame_end, input ready);
	modport sink (input valid, hue, saturation, brightness, frame_end, output ready);
endinterface

interface fvh_cfg_if;
	logic valid;
	logic ready;
	logic data;

	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface

[sv/fvh_ctrl.sv]
// ----------------------------------------------------------------------------
// fvh_ctrl: sequencing state machine of the flow vector to HSV coder
// Steps the datapath through squaring, root and angle search, division and
// result hand-off, and owns the shared step counter.
// ----------------------------------------------------------------------------
module fvh_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  fvh_pkg::fvh_status_t status,
	output fvh_pkg::fvh_cmd_t    cmd
);
	import fvh_pkg::*;

	fvh_state_t state_q, state_d;
	logic [5:0] cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q != state_d)
				cnt_q <= '0;
			else
				cnt_q <= cnt_q + 6'd1;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:     if (in_valid) state_d = ST_SQUARE;
			ST_SQUARE:   state_d = ST_SUM;
			ST_SUM:      state_d = ST_ITERATE;
			ST_ITERATE:  if (cnt_q == 6'(ANGLE_STEPS - 1)) state_d = ST_DIV_PREP;
			ST_DIV_PREP: state_d = ST_DIVIDE;
			ST_DIVIDE:   if (cnt_q == 6'(DIV_STEPS - 1)) state_d = ST_FINISH;
			ST_FINISH:   if (!status.out_stall) state_d = ST_IDLE;
			default:     state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd          = '0;
		cmd.cnt      = cnt_q;
		in_ready     = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			ST_SQUARE:   cmd.square   = 1'b1;
			ST_SUM:      cmd.sum      = 1'b1;
			ST_ITERATE:  cmd.iterate  = 1'b1;
			ST_DIV_PREP: cmd.div_prep = 1'b1;
			ST_DIVIDE:   cmd.div_step = 1'b1;
			ST_FINISH:   cmd.finish   = !status.out_stall;
			default:     cmd          = '0;
		endcase
	end

endmodule

[sv/fvh_dp.sv]
// ----------------------------------------------------------------------------
// fvh_dp: datapath of the flow vector to HSV coder
// Quadrant reduction, squares, bit-serial square root, angle boundary search,
// restoring division, peak tracking and the output register.
// ----------------------------------------------------------------------------
module fvh_dp #(
	parameter int FLOW_BITS = fvh_pkg::FLOW_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  fvh_pkg::fvh_cmd_t           cmd,
	output fvh_pkg::fvh_status_t        status,
	input  logic signed [FLOW_BITS-1:0] flow_x,
	input  logic signed [FLOW_BITS-1:0] flow_y,
	input  logic                        frame_last,
	input  logic                        cfg_valid,
	input  logic                        cfg_data,
	input  logic                        out_ready,
	output logic                        out_valid,
	output logic [7:0]                  hue,
	output logic [7:0]                  brightness,
	output logic                        frame_end
);
	import fvh_pkg::*;

	localparam int N  = FLOW_BITS;
	localparam int W2 = 2 * FLOW_BITS;

	logic [N-1:0]    u_q, v_q, ax_q, ay_q;
	logic [1:0]      quad_q;
	logic            zero_q, last_q, mode_q;
	logic [W2-1:0]   sqx_s1, sqy_s1;
	logic [W2-1:0]   s_q, root_q, bit_q;
	logic [5:0]      c_q;
	logic [N+7:0]    rem_q;
	logic [7:0]      quo_q;
	logic            sat_q;
	logic [N-1:0]    peak_prev_q, peak_run_q;
	logic            out_valid_q;
	logic [7:0]      hue_q, bright_q;
	logic            frame_end_q;

	// Input reduction.
	logic [N-1:0] ax, ay;
	logic         x_pos, x_neg, y_pos, y_neg, odd_quad;
	logic [1:0]   quad;

	always_comb begin
		ax    = flow_x[N-1] ? N'(-flow_x) : N'(flow_x);
		ay    = flow_y[N-1] ? N'(-flow_y) : N'(flow_y);
		x_neg = flow_x[N-1];
		y_neg = flow_y[N-1];
		x_pos = !x_neg && (flow_x != '0);
		y_pos = !y_neg && (flow_y != '0);
		if (x_pos && !y_neg)
			quad = 2'd0;
		else if (!x_pos && y_pos)
			quad = 2'd1;
		else if (x_neg && !y_pos)
			quad = 2'd2;
		else
			quad = 2'd3;
		odd_quad = quad[0];
	end

	// Root step.
	logic [W2-1:0] trial;
	logic          root_active;
	assign trial       = root_q + bit_q;
	assign root_active = cmd.cnt < 6'(N);

	// Angle boundary test: boundary k = cnt + 1.
	logic [5:0]      kk, kmir;
	logic            low_half;
	logic [4:0]      tidx;
	logic [N-1:0]    mul_a, other;
	logic [N+19:0]   prod, shifted;
	logic            reached;

	always_comb begin
		kk       = cmd.cnt + 6'd1;
		kmir     = 6'(TAN_MIRROR) - kk;
		low_half = kk <= 6'(TAN_LAST);
		tidx     = low_half ? kk[4:0] : kmir[4:0];
		mul_a    = low_half ? u_q : v_q;
		other    = low_half ? v_q : u_q;
		prod     = (N+20)'(mul_a) * (N+20)'(tan_lut(tidx));
		shifted  = (N+20)'(other) << TAN_SHIFT;
		reached  = low_half ? (shifted >= prod) : (prod >= shifted);
	end

	// Division.
	logic [N-1:0]  mag;
	logic [N+7:0]  dividend, dstep;
	logic [2:0]    qbit;
	assign mag      = root_q[N-1:0];
	assign dividend = {mag, 8'b0} - {8'b0, mag};
	assign qbit     = 3'd7 - cmd.cnt[2:0];
	assign dstep    = {8'b0, peak_prev_q} << qbit;

	// Result.
	logic [7:0]   bright_d, hue_d;
	logic [N-1:0] peak_new;

	always_comb begin
		if (mode_q)
			bright_d = 8'd255;
		else if (peak_prev_q == '0)
			bright_d = (mag == '0) ? 8'd0 : 8'd255;
		else if (sat_q)
			bright_d = 8'd255;
		else
			bright_d = quo_q;
		hue_d    = zero_q ? 8'd0 : quad_base(quad_q) + 8'(c_q);
		peak_new = (mag > peak_run_q) ? mag : peak_run_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= 1'b0;
			peak_prev_q <= '0;
			peak_run_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid)
				mode_q <= cfg_data;
			if (cmd.finish) begin
				out_valid_q <= 1'b1;
				if (last_q) begin
					peak_prev_q <= peak_new;
					peak_run_q  <= '0;
				end else begin
					peak_run_q <= peak_new;
				end
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			ax_q   <= ax;
			ay_q   <= ay;
			u_q    <= odd_quad ? ay : ax;
			v_q    <= odd_quad ? ax : ay;
			quad_q <= quad;
			zero_q <= (flow_x == '0) && (flow_y == '0);
			last_q <= frame_last;
		end
		if (cmd.square) begin
			sqx_s1 <= W2'(ax_q) * W2'(ax_q);
			sqy_s1 <= W2'(ay_q) * W2'(ay_q);
		end
		if (cmd.sum) begin
			s_q    <= sqx_s1 + sqy_s1;
			root_q <= '0;
			bit_q  <= W2'(1) << (W2 - 2);
			c_q    <= '0;
		end
		if (cmd.iterate) begin
			if (root_active) begin
				if (s_q >= trial) begin
					s_q    <= s_q - trial;
					root_q <= (root_q >> 1) + bit_q;
				end else begin
					root_q <= root_q >> 1;
				end
				bit_q <= bit_q >> 2;
			end
			if (reached)
				c_q <= c_q + 6'd1;
		end
		if (cmd.div_prep) begin
			rem_q <= dividend;
			quo_q <= '0;
			sat_q <= dividend >= {peak_prev_q, 8'b0};
		end
		if (cmd.div_step) begin
			if (rem_q >= dstep) begin
				rem_q       <= rem_q - dstep;
				quo_q[qbit] <= 1'b1;
			end
		end
		if (cmd.finish) begin
			hue_q       <= hue_d;
			bright_q    <= bright_d;
			frame_end_q <= last_q;
		end
	end

	assign status.out_stall = out_valid_q && !out_ready;
	assign out_valid        = out_valid_q;
	assign hue              = hue_q;
	assign brightness       = bright_q;
	assign frame_end        = frame_end_q;

endmodule

[sv/flow_vector_to_hsv.sv]
// ----------------------------------------------------------------------------
// flow_vector_to_hsv: optical flow vector to HSV color coder
// Turns one flow vector per pixel into hue, saturation and brightness bytes.
// ----------------------------------------------------------------------------
// Usage:
// Flow vectors enter on flow_in, one item per pixel, with frame_last set on
// the last pixel of a frame. Each item gives exactly one HSV item on hsv_out.
// The cfg channel writes the one-bit value mode and is always ready. It must
// be written only while no pixel is in flight; the block does not enforce it.
// An item goes from acceptance to its result in the output register through
// the squares and their sum, the 44-step angle boundary search (the square
// root runs bit by bit inside that window, one result bit per cycle), one
// setup step and the restoring divider, and the load of the result. One item
// is worked on at a time, so a new item is taken only once the last result
// is loaded; the 44-step angle search takes the largest share of that time.
// The input is taken again as soon as the result is loaded, even while the
// receiver has not yet taken it. If the receiver stalls, the result holds in
// the output register and the next item waits in its final step.
// Reset clears the mode to magnitude and both peak registers to zero.
// ----------------------------------------------------------------------------
module flow_vector_to_hsv #(
	parameter int FLOW_BITS = fvh_pkg::FLOW_BITS_DEF
) (
	input logic                 clk,
	input logic                 arst_n,
	fvh_flow_if.sink            flow_in,
	fvh_hsv_if.source           hsv_out,
	fvh_cfg_if.sink             cfg
);
	import fvh_pkg::*;

	fvh_cmd_t    cmd;
	fvh_status_t status;

	// The controller sequences every item; the datapath only follows commands.
	fvh_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (flow_in.valid),
		.in_ready (flow_in.ready),
		.status   (status),
		.cmd      (cmd)
	);

	fvh_dp #(
		.FLOW_BITS (FLOW_BITS)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.status     (status),
		.flow_x     (flow_in.flow_x),
		.flow_y     (flow_in.flow_y),
		.frame_last (flow_in.frame_last),
		.cfg_valid  (cfg.valid),
		.cfg_data   (cfg.data),
		.out_ready  (hsv_out.ready),
		.out_valid  (hsv_out.valid),
		.hue        (hsv_out.hue),
		.brightness (hsv_out.brightness),
		.frame_end  (hsv_out.frame_end)
	);

	// Configuration writes never wait.
	assign cfg.ready          = 1'b1;
	// Saturation is always full.
	assign hsv_out.saturation = 8'd255;

endmodule
